@@ design/bpps_pkg.sv @@
// ----------------------------------------------------------------------------
// bpps_pkg
// Types, constants, latencies and table builders for the point-light shader.
// ----------------------------------------------------------------------------
`default_nettype none

package bpps_pkg;

  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int EXP_TABLE_ENTRIES = 256;

  localparam int LOG_IDX_W  = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int EXP_IDX_W  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int LOG_PROD_W = 15 + LOG_IDX_W;
  localparam int EXP_PROD_W = 16 + EXP_IDX_W;

  localparam int SQRT_STEPS    = 25;
  localparam int COS_DIV_STEPS = 16;
  localparam int ATT_DIV_STEPS = 17;
  localparam int COS_LAT       = 6 + SQRT_STEPS + COS_DIV_STEPS + 2;
  localparam int ATT_LAT       = 3 + ATT_DIV_STEPS + 1;
  localparam int POW_LAT       = 10;
  localparam int SIDE_DLY      = COS_LAT + POW_LAT;
  localparam int ATT_DLY       = SIDE_DLY - ATT_LAT;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_LIGHT_RGBA = 3'd3,
    CFG_EYE_X      = 3'd4,
    CFG_EYE_Y      = 3'd5,
    CFG_EYE_Z      = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        shininess;
    logic [47:0]        specular_rgb;
    logic [47:0]        diffuse_rgb;
  } in_t;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    logic [16:0] alpha;
  } out_t;

  typedef struct packed {
    logic        zero;
    logic [15:0] value;
  } cos_res_t;

  typedef struct packed {
    logic        facing;
    logic [16:0] atten;
  } att_res_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [16:0] log_entry(input int idx);
    logic [63:0] y;
    logic [63:0] res;
    y = (64'd1 << 30) + ((64'(idx) << 30) / LOG_TABLE_ENTRIES);
    res = '0;
    if (y >= (64'd1 << 31)) begin
      y = y >> 1;
      res = res + 64'd65536;
    end
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        res = res + (64'd1 << (15 - k));
        y = y >> 1;
      end
    end
    return res[16:0];
  endfunction

  function automatic logic [31:0] exp_entry(input int idx);
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] rt;
    f = (64'(idx) << 16) / EXP_TABLE_ENTRIES;
    r = 64'd1 << 30;
    if (f >= 64'd65536) begin
      r = 64'd1 << 31;
    end else begin
      rt = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) begin
        rt = isqrt_c(rt << 30);
        if (f[16-k]) begin
          r = (r * rt) >> 30;
        end
      end
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

@@ design/bpps_cosine.sv @@
// ----------------------------------------------------------------------------
// bpps_cosine
// Pipelined clamped cosine between a normal and a direction vector (Q1.15).
// ----------------------------------------------------------------------------
`default_nettype none

module bpps_cosine (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  n [3],
  input  logic signed [33:0]  v [3],
  output bpps_pkg::cos_res_t  res
);
  import bpps_pkg::*;

  logic [33:0]        mag1 [3];
  logic [2:0]         neg1;
  logic signed [15:0] n1 [3];
  logic [33:0]        mag2 [3];
  logic [33:0]        max2;
  logic [2:0]         neg2;
  logic signed [15:0] n2 [3];
  logic [33:0]        mag3 [3];
  logic [5:0]         pos3;
  logic               zero3;
  logic [2:0]         neg3;
  logic signed [15:0] n3 [3];
  logic [23:0]        w4 [3];
  logic               zero4;
  logic [2:0]         neg4;
  logic signed [15:0] n4 [3];
  logic signed [40:0] pn5 [3];
  logic [47:0]        sq5 [3];
  logic               zero5;

  logic [33:0]        max_c;
  logic [5:0]         pos_c;
  logic [33:0]        sh_c [3];
  logic signed [24:0] sw_c [3];

  logic [49:0]        sqx [SQRT_STEPS+1];
  logic [51:0]        sqr [SQRT_STEPS+1];
  logic signed [42:0] sqd [SQRT_STEPS+1];
  logic               sqz [SQRT_STEPS+1];

  logic [42:0]        drem [COS_DIV_STEPS+1];
  logic [15:0]        dq   [COS_DIV_STEPS+1];
  logic [24:0]        dlen [COS_DIV_STEPS+1];
  logic               dov  [COS_DIV_STEPS+1];
  logic               dpos [COS_DIV_STEPS+1];
  logic               dz   [COS_DIV_STEPS+1];

  logic [42:0]        num_c;

  always_comb begin
    max_c = mag1[0];
    if (mag1[1] > max_c) max_c = mag1[1];
    if (mag1[2] > max_c) max_c = mag1[2];
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 34; i++) begin
      if (max2[i]) pos_c = 6'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos3 >= 6'd24) begin
        sh_c[i] = mag3[i] >> (pos3 - 6'd23);
      end else begin
        sh_c[i] = mag3[i] << (6'd23 - pos3);
      end
      sw_c[i] = neg4[i] ? (25'd0 - {1'b0, w4[i]}) : {1'b0, w4[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= v[i][33];
        mag1[i] <= v[i][33] ? (34'd0 - v[i]) : v[i];
        n1[i]   <= n[i];
        mag2[i] <= mag1[i];
        n2[i]   <= n1[i];
        mag3[i] <= mag2[i];
        n3[i]   <= n2[i];
        w4[i]   <= sh_c[i][23:0];
        n4[i]   <= n3[i];
        pn5[i]  <= $signed(n4[i]) * $signed(sw_c[i]);
        sq5[i]  <= w4[i] * w4[i];
      end
      neg2   <= neg1;
      max2   <= max_c;
      neg3   <= neg2;
      pos3   <= pos_c;
      zero3  <= (max2 == '0);
      neg4   <= neg3;
      zero4  <= zero3;
      zero5  <= zero4;
      sqd[0] <= pn5[0] + pn5[1] + pn5[2];
      sqx[0] <= 50'(sq5[0]) + 50'(sq5[1]) + 50'(sq5[2]);
      sqr[0] <= '0;
      sqz[0] <= zero5;
    end
  end

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam logic [51:0] BIT = 52'd1 << (2 * (SQRT_STEPS - 1 - s));
    logic [51:0] trial;
    assign trial = sqr[s] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, sqx[s]} >= trial) begin
          sqx[s+1] <= 50'({2'b00, sqx[s]} - trial);
          sqr[s+1] <= (sqr[s] >> 1) + BIT;
        end else begin
          sqx[s+1] <= sqx[s];
          sqr[s+1] <= sqr[s] >> 1;
        end
        sqd[s+1] <= sqd[s];
        sqz[s+1] <= sqz[s];
      end
    end
  end

  assign num_c = {sqd[SQRT_STEPS][41:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= num_c;
      dq[0]   <= '0;
      dlen[0] <= sqr[SQRT_STEPS][24:0];
      dov[0]  <= {2'b00, num_c} >= {20'd0, sqr[SQRT_STEPS][24:0], 16'd0} + 61'd0;
      dpos[0] <= !sqz[SQRT_STEPS] && (sqd[SQRT_STEPS] > 43'sd0);
      dz[0]   <= sqz[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < COS_DIV_STEPS; j++) begin : g_div
    localparam int K = COS_DIV_STEPS - 1 - j;
    logic [42:0] dv;
    assign dv = 43'(dlen[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        if (drem[j] >= dv) begin
          drem[j+1] <= drem[j] - dv;
          dq[j+1]   <= dq[j] | (16'd1 << K);
        end else begin
          drem[j+1] <= drem[j];
          dq[j+1]   <= dq[j];
        end
        dlen[j+1] <= dlen[j];
        dov[j+1]  <= dov[j];
        dpos[j+1] <= dpos[j];
        dz[j+1]   <= dz[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.zero <= dz[COS_DIV_STEPS];
      if (!dpos[COS_DIV_STEPS]) begin
        res.value <= '0;
      end else if (dov[COS_DIV_STEPS] || dq[COS_DIV_STEPS] > 16'd32768) begin
        res.value <= 16'd32768;
      end else begin
        res.value <= dq[COS_DIV_STEPS];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bpps_atten.sv @@
// ----------------------------------------------------------------------------
// bpps_atten
// Facing test and pipelined distance attenuation 1/(1+d^2) in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module bpps_atten (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  n [3],
  input  logic signed [32:0]  l [3],
  output bpps_pkg::att_res_t  res
);
  import bpps_pkg::*;

  logic [32:0]        mag1 [3];
  logic signed [48:0] fp1 [3];
  logic               big1;
  logic [47:0]        sq2 [3];
  logic               big2;
  logic               face2;
  logic [49:0]        sum_c;
  logic signed [50:0] face_c;

  logic [48:0] arem [ATT_DIV_STEPS+1];
  logic [16:0] aq   [ATT_DIV_STEPS+1];
  logic [48:0] aden [ATT_DIV_STEPS+1];
  logic        az   [ATT_DIV_STEPS+1];
  logic        af   [ATT_DIV_STEPS+1];

  assign face_c = fp1[0] + fp1[1] + fp1[2];
  assign sum_c  = 50'(sq2[0]) + 50'(sq2[1]) + 50'(sq2[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      big1 <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= l[i][32] ? (33'd0 - l[i]) : l[i];
        fp1[i]  <= $signed(n[i]) * $signed(l[i]);
        if ((l[i][32] ? (33'd0 - l[i]) : l[i]) >= 33'h100_0000) big1 <= 1'b1;
        sq2[i]  <= mag1[i][23:0] * mag1[i][23:0];
      end
      big2    <= big1;
      face2   <= !face_c[50];
      arem[0] <= 49'h1_0000_0000_0000;
      aq[0]   <= '0;
      aden[0] <= 49'h1_0000_0000 + 49'(sum_c[47:0]);
      az[0]   <= big2 || (sum_c[49:48] != 2'b00);
      af[0]   <= face2;
    end
  end

  for (genvar j = 0; j < ATT_DIV_STEPS; j++) begin : g_div
    localparam int K = ATT_DIV_STEPS - 1 - j;
    logic [65:0] dv;
    assign dv = 66'(aden[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        if (66'(arem[j]) >= dv) begin
          arem[j+1] <= arem[j] - dv[48:0];
          aq[j+1]   <= aq[j] | (17'd1 << K);
        end else begin
          arem[j+1] <= arem[j];
          aq[j+1]   <= aq[j];
        end
        aden[j+1] <= aden[j];
        az[j+1]   <= az[j];
        af[j+1]   <= af[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.facing <= af[ATT_DIV_STEPS];
      res.atten  <= az[ATT_DIV_STEPS] ? 17'd0 : aq[ATT_DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

@@ design/bpps_pow.sv @@
// ----------------------------------------------------------------------------
// bpps_pow
// Pipelined cosine^shininess through log2 and exp2 tables with interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module bpps_pow (
  input  logic               clk,
  input  logic               en,
  input  bpps_pkg::cos_res_t cos,
  input  logic [15:0]        shin,
  output logic [15:0]        power
);
  import bpps_pkg::*;

  logic [16:0] lt [LOG_TABLE_ENTRIES+1];
  logic [31:0] et [EXP_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_lt
    localparam logic [16:0] VAL = log_entry(g);
    assign lt[g] = VAL;
  end

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_et
    localparam logic [31:0] VAL = exp_entry(g);
    assign et[g] = VAL;
  end

  logic [3:0]  pos_c;
  logic [15:0] mant_sh;
  logic        spec_c;
  logic [15:0] specv_c;

  logic        spec_s  [1:9];
  logic [15:0] specv_s [1:9];
  logic [3:0]  p_s     [1:4];
  logic [15:0] s_s     [1:5];

  logic [14:0]           mant1;
  logic [LOG_IDX_W-1:0]  idx2;
  logic [14:0]           rem2;
  logic [16:0]           lo3;
  logic [16:0]           diff3;
  logic [14:0]           rem3;
  logic [16:0]           lo4;
  logic [31:0]           prod4;
  logic [19:0]           l5;
  logic [27:0]           e6;
  logic [EXP_IDX_W-1:0]  idx7;
  logic [15:0]           rem7;
  logic [4:0]            q7;
  logic                  big7;
  logic                  fz7;
  logic [31:0]           lo8;
  logic [31:0]           diff8;
  logic [15:0]           rem8;
  logic [4:0]            q8;
  logic                  big8;
  logic                  fz8;
  logic [31:0]           lo9;
  logic [47:0]           prod9;
  logic [4:0]            q9;
  logic                  big9;
  logic                  fz9;

  logic [LOG_PROD_W-1:0] lm_c;
  logic [17:0]           lg_c;
  logic [19:0]           l0_c;
  logic [35:0]           ls_c;
  logic [15:0]           g_c;
  logic [EXP_PROD_W-1:0] gm_c;
  logic [32:0]           v_c;
  logic [5:0]            sh_c;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (cos.value[i]) pos_c = 4'(i);
    end
    mant_sh = cos.value << (4'd15 - pos_c);
    spec_c  = (cos.value == '0) || (shin == '0);
    if (cos.zero) begin
      specv_c = '0;
    end else if (cos.value == '0) begin
      specv_c = (shin == '0) ? 16'd32768 : 16'd0;
    end else begin
      specv_c = 16'd32768;
    end
  end

  assign lm_c = LOG_PROD_W'(mant1) * LOG_PROD_W'(LOG_TABLE_ENTRIES);
  assign lg_c = 18'(lo4) + 18'(prod4 >> 15);
  assign l0_c = {4'd15 - p_s[4], 16'd0};
  assign ls_c = 36'(l5) * 36'(s_s[5]);
  assign g_c  = (e6[15:0] == '0) ? 16'd0 : 16'(17'h1_0000 - 17'(e6[15:0]));
  assign gm_c = EXP_PROD_W'(g_c) * EXP_PROD_W'(EXP_TABLE_ENTRIES);
  assign v_c  = 33'(lo9) + 33'(prod9 >> 16);
  assign sh_c = 6'd16 + 6'(q9);

  always_ff @(posedge clk) begin
    if (en) begin
      spec_s[1]  <= spec_c;
      specv_s[1] <= specv_c;
      for (int k = 2; k <= 9; k++) begin
        spec_s[k]  <= spec_s[k-1];
        specv_s[k] <= specv_s[k-1];
      end
      p_s[1] <= pos_c;
      for (int k = 2; k <= 4; k++) p_s[k] <= p_s[k-1];
      s_s[1] <= shin;
      for (int k = 2; k <= 5; k++) s_s[k] <= s_s[k-1];

      mant1 <= mant_sh[14:0];
      idx2  <= lm_c[LOG_PROD_W-1:15];
      rem2  <= lm_c[14:0];
      lo3   <= lt[idx2];
      diff3 <= lt[idx2 + LOG_IDX_W'(1)] - lt[idx2];
      rem3  <= rem2;
      lo4   <= lo3;
      prod4 <= 32'(diff3) * 32'(rem3);
      l5    <= (l0_c > 20'(lg_c)) ? (l0_c - 20'(lg_c)) : 20'd0;
      e6    <= ls_c[35:8];
      idx7  <= gm_c[EXP_PROD_W-1:16];
      rem7  <= gm_c[15:0];
      q7    <= e6[20:16];
      big7  <= (e6[27:16] >= 12'd31);
      fz7   <= (e6[15:0] == '0);
      lo8   <= et[idx7];
      diff8 <= et[idx7 + EXP_IDX_W'(1)] - et[idx7];
      rem8  <= rem7;
      q8    <= q7;
      big8  <= big7;
      fz8   <= fz7;
      lo9   <= lo8;
      prod9 <= 48'(diff8) * 48'(rem8);
      q9    <= q8;
      big9  <= big8;
      fz9   <= fz8;
      if (spec_s[9]) begin
        power <= specv_s[9];
      end else if (big9) begin
        power <= '0;
      end else if (fz9) begin
        power <= 16'd32768 >> q9;
      end else begin
        power <= 16'(v_c >> sh_c);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/blinn_phong_point_light_shader.sv @@
// ----------------------------------------------------------------------------
// blinn_phong_point_light_shader
// Blinn-Phong shading of one hit point under one point light, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock while the output is not stalled. The
// depth is set by the two cosine units (a 25-stage square root and a 16-stage
// divider each), the 10-stage pow unit and the colour multipliers; attenuation
// runs alongside in its own 17-stage divider. When the output is stalled the
// whole pipeline holds. Configuration registers are read live by the input and
// colour stages, so write them only while idle.
`default_nettype none

module blinn_phong_point_light_shader (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bpps_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bpps_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [bpps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);
  import bpps_pkg::*;

  logic [31:0] light_x, light_y, light_z, eye_x, eye_y, eye_z;
  logic [63:0] light_rgba;

  logic adv;

  logic [31:0]        pt_c [3];
  logic [31:0]        lp_c [3];
  logic [31:0]        ep_c [3];
  logic [32:0]        l_c  [3];
  logic [32:0]        e_c  [3];

  logic               v1;
  logic signed [32:0] l1  [3];
  logic signed [33:0] lx1 [3];
  logic signed [33:0] h1  [3];
  logic signed [15:0] n1  [3];
  logic [15:0]        shin1;
  logic [47:0]        ks1, kd1;

  logic [15:0] shin_d [COS_LAT];
  logic [47:0] ks_d   [SIDE_DLY];
  logic [47:0] kd_d   [SIDE_DLY];
  logic        vline  [SIDE_DLY];
  cos_res_t    d_d    [POW_LAT];
  att_res_t    a_d    [ATT_DLY];

  cos_res_t    cos_l, cos_h;
  att_res_t    att;
  logic [15:0] power;

  logic        vk1, vk2, vk3, vk4;
  att_res_t    ak1, ak2, ak3, ak4;
  logic [31:0] pk1 [3];
  logic [31:0] dk1 [3];
  logic [32:0] t2  [3];
  logic [48:0] tl3 [3];
  logic [65:0] ta4 [3];
  logic [16:0] col_c [3];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x    <= '0;
      light_y    <= '0;
      light_z    <= '0;
      light_rgba <= '0;
      eye_x      <= '0;
      eye_y      <= '0;
      eye_z      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIGHT_X:    light_x    <= cfg_data[31:0];
        CFG_LIGHT_Y:    light_y    <= cfg_data[31:0];
        CFG_LIGHT_Z:    light_z    <= cfg_data[31:0];
        CFG_LIGHT_RGBA: light_rgba <= cfg_data;
        CFG_EYE_X:      eye_x      <= cfg_data[31:0];
        CFG_EYE_Y:      eye_y      <= cfg_data[31:0];
        CFG_EYE_Z:      eye_z      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pt_c[0] = in_data.point_x;
    pt_c[1] = in_data.point_y;
    pt_c[2] = in_data.point_z;
    lp_c[0] = light_x;
    lp_c[1] = light_y;
    lp_c[2] = light_z;
    ep_c[0] = eye_x;
    ep_c[1] = eye_y;
    ep_c[2] = eye_z;
    for (int i = 0; i < 3; i++) begin
      l_c[i] = {lp_c[i][31], lp_c[i]} - {pt_c[i][31], pt_c[i]};
      e_c[i] = {ep_c[i][31], ep_c[i]} - {pt_c[i][31], pt_c[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        l1[i] <= l_c[i];
        h1[i] <= {l_c[i][32], l_c[i]} + {e_c[i][32], e_c[i]};
      end
      n1[0] <= in_data.normal_x;
      n1[1] <= in_data.normal_y;
      n1[2] <= in_data.normal_z;
      shin1 <= in_data.shininess;
      ks1   <= in_data.specular_rgb;
      kd1   <= in_data.diffuse_rgb;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) lx1[i] = {l1[i][32], l1[i]};
  end

  bpps_cosine u_cos_l (
    .clk (clk),
    .en  (adv),
    .n   (n1),
    .v   (lx1),
    .res (cos_l)
  );

  bpps_cosine u_cos_h (
    .clk (clk),
    .en  (adv),
    .n   (n1),
    .v   (h1),
    .res (cos_h)
  );

  bpps_atten u_atten (
    .clk (clk),
    .en  (adv),
    .n   (n1),
    .l   (l1),
    .res (att)
  );

  bpps_pow u_pow (
    .clk   (clk),
    .en    (adv),
    .cos   (cos_h),
    .shin  (shin_d[COS_LAT-1]),
    .power (power)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      shin_d[0] <= shin1;
      for (int i = 1; i < COS_LAT; i++) shin_d[i] <= shin_d[i-1];
      ks_d[0] <= ks1;
      kd_d[0] <= kd1;
      for (int i = 1; i < SIDE_DLY; i++) begin
        ks_d[i] <= ks_d[i-1];
        kd_d[i] <= kd_d[i-1];
      end
      d_d[0] <= cos_l;
      for (int i = 1; i < POW_LAT; i++) d_d[i] <= d_d[i-1];
      a_d[0] <= att;
      for (int i = 1; i < ATT_DLY; i++) a_d[i] <= a_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_DLY; i++) vline[i] <= 1'b0;
      vk1       <= 1'b0;
      vk2       <= 1'b0;
      vk3       <= 1'b0;
      vk4       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vline[0] <= v1;
      for (int i = 1; i < SIDE_DLY; i++) vline[i] <= vline[i-1];
      vk1       <= vline[SIDE_DLY-1];
      vk2       <= vk1;
      vk3       <= vk2;
      vk4       <= vk3;
      out_valid <= vk4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_c[i] = (ta4[i][65:63] != 3'b000) ? 17'h1_FFFF : ta4[i][62:46];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ak1 <= a_d[ATT_DLY-1];
      ak2 <= ak1;
      ak3 <= ak2;
      ak4 <= ak3;
      for (int i = 0; i < 3; i++) begin
        pk1[i] <= 32'(power) * 32'(ks_d[SIDE_DLY-1][16*i +: 16]);
        dk1[i] <= 32'(d_d[POW_LAT-1].value) * 32'(kd_d[SIDE_DLY-1][16*i +: 16]);
        t2[i]  <= 33'(pk1[i]) + 33'(dk1[i]);
        tl3[i] <= 49'(t2[i]) * 49'(light_rgba[16*i +: 16]);
        ta4[i] <= 66'(tl3[i]) * 66'(ak3.atten);
      end
      if (ak4.facing) begin
        out_data.red   <= col_c[0];
        out_data.green <= col_c[1];
        out_data.blue  <= col_c[2];
        out_data.alpha <= {light_rgba[63:48], 1'b0};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point-light shader. Hit points go in through a
// queue-fed driver. Every accepted transaction is shaded by a fixed-point
// predictor in the bench, and a monitor checks each result against the oldest
// prediction. The bench runs several light and eye scenes and several idle
// and stall mixes, including a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpps_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef longint vec3_t[3];

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  blinn_phong_point_light_shader uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_t hit_q[$];
  out_t shade_q[$];
  longint unsigned log_tab[LOG_TABLE_ENTRIES+1];
  longint unsigned exp_tab[EXP_TABLE_ENTRIES+1];
  logic [31:0] light_x, light_y, light_z, eye_x, eye_y, eye_z;
  logic [63:0] light_rgba;
  int snd_idle, rcv_idle;
  bit want_hold, hold_done;
  int hold_left;
  int mismatches, shaded, checked, scenes, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_tables();
    longint unsigned roots[17];
    longint unsigned y, res, f, r;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) roots[k] = sqrt_floor(roots[k-1] << 30);
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      res = 0;
      while (y >= (64'd1 << 31)) begin
        y = y >> 1;
        res += 65536;
      end
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          res += 64'd1 << (15 - k);
          y = y >> 1;
        end
      end
      log_tab[i] = res;
    end
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      f = (64'(i) << 16) / EXP_TABLE_ENTRIES;
      r = 64'd1 << 30;
      if (f >= 65536) r = 64'd1 << 31;
      else
        for (int k = 1; k <= 16; k++)
          if ((f >> (16 - k)) & 1) r = (r * roots[k]) >> 30;
      exp_tab[i] = r;
    end
  endfunction

  function automatic longint unsigned cos_q15(vec3_t n, vec3_t v, output bit zero);
    longint unsigned mag[3];
    longint unsigned m, len2, c;
    longint w, dot;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    zero = (m == 0);
    if (zero) return 0;
    while (m >= (64'd1 << 24)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 23)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    dot = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      w = v[i] < 0 ? -longint'(mag[i]) : longint'(mag[i]);
      dot += n[i] * w;
      len2 += mag[i] * mag[i];
    end
    if (dot <= 0) return 0;
    c = (longint'(dot) * 2) / sqrt_floor(len2);
    return c > 32768 ? 64'd32768 : c;
  endfunction

  function automatic longint unsigned pow_q15(longint unsigned c, longint unsigned s);
    int p;
    longint unsigned mant, idx, rem, lg, lval, e, q, f, g, v;
    if (c == 0) return s == 0 ? 64'd32768 : 64'd0;
    if (s == 0) return 32768;
    p = 15;
    while (c[p] == 1'b0) p--;
    mant = (c << (15 - p)) & 64'h7FFF;
    idx = (mant * LOG_TABLE_ENTRIES) >> 15;
    rem = mant * LOG_TABLE_ENTRIES - (idx << 15);
    lg = log_tab[idx] + (((log_tab[idx+1] - log_tab[idx]) * rem) >> 15);
    lval = 64'(15 - p) * 65536;
    lval = lval > lg ? lval - lg : 0;
    e = (lval * s) >> 8;
    q = e >> 16;
    f = e & 64'hFFFF;
    if (q >= 31) return 0;
    if (f == 0) return 64'd32768 >> q;
    g = 65536 - f;
    idx = (g * EXP_TABLE_ENTRIES) >> 16;
    rem = g * EXP_TABLE_ENTRIES - (idx << 16);
    v = exp_tab[idx] + (((exp_tab[idx+1] - exp_tab[idx]) * rem) >> 16);
    return v >> (16 + q);
  endfunction

  function automatic out_t shade(in_t it);
    vec3_t n, l, h;
    longint pt[3], lp[3], ep[3];
    longint face;
    longint unsigned mg, s_sum, att, dif, spec, ks, kd, lc, t, r;
    bit big, lz, hz;
    out_t o;
    lp = '{longint'(signed'(light_x)), longint'(signed'(light_y)),
           longint'(signed'(light_z))};
    ep = '{longint'(signed'(eye_x)), longint'(signed'(eye_y)), longint'(signed'(eye_z))};
    pt = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
    n = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
    face = 0;
    for (int i = 0; i < 3; i++) begin
      l[i] = lp[i] - pt[i];
      h[i] = l[i] + (ep[i] - pt[i]);
      face += n[i] * l[i];
    end
    o = '0;
    if (face < 0) return o;
    big = 0;
    s_sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = l[i] < 0 ? longint'(-l[i]) : longint'(l[i]);
      if (mg >= (64'd1 << 24)) big = 1;
      else s_sum += mg * mg;
    end
    att = (big || s_sum >= (64'd1 << 48)) ? 0 : (64'd1 << 48) / ((64'd1 << 32) + s_sum);
    dif = cos_q15(n, l, lz);
    spec = cos_q15(n, h, hz);
    spec = hz ? 0 : pow_q15(spec, 64'(it.shininess));
    for (int i = 0; i < 3; i++) begin
      ks = (it.specular_rgb >> (16 * i)) & 64'hFFFF;
      kd = (it.diffuse_rgb >> (16 * i)) & 64'hFFFF;
      lc = (light_rgba >> (16 * i)) & 64'hFFFF;
      t = spec * ks + dif * kd;
      r = ((t * lc) * att) >> 46;
      if (r > 131071) r = 131071;
      case (i)
        0: o.red = r[16:0];
        1: o.green = r[16:0];
        default: o.blue = r[16:0];
      endcase
    end
    o.alpha = {light_rgba[63:48], 1'b0};
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shade_q.push_back(shade(in_data));
        shaded++;
      end
      if (!in_valid || !in_stall) begin
        if (hit_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          in_data <= hit_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      checked++;
      if (shade_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = shade_q.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue || out_data.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                     checked, want.red, want.green, want.blue, want.alpha,
                     out_data.red, out_data.green, out_data.blue, out_data.alpha);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (cfg_index_t'(idx))
      CFG_LIGHT_X: light_x = d[31:0];
      CFG_LIGHT_Y: light_y = d[31:0];
      CFG_LIGHT_Z: light_z = d[31:0];
      CFG_LIGHT_RGBA: light_rgba = d;
      CFG_EYE_X: eye_x = d[31:0];
      CFG_EYE_Y: eye_y = d[31:0];
      CFG_EYE_Z: eye_z = d[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scene(logic [31:0] lx, ly, lz, logic [63:0] rgba,
                           logic [31:0] ex, ey, ez);
    write_reg(CFG_LIGHT_X, {$urandom, lx});
    write_reg(CFG_LIGHT_Y, {32'h0, ly});
    write_reg(CFG_LIGHT_Z, {32'hFFFF_FFFF, lz});
    write_reg(CFG_LIGHT_RGBA, rgba);
    write_reg(CFG_EYE_X, {32'h0, ex});
    write_reg(CFG_EYE_Y, {$urandom, ey});
    write_reg(CFG_EYE_Z, {32'h0, ez});
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    scenes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (hit_q.size() > 0 || in_valid || shade_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] jitter(logic [31:0] base);
    int k;
    logic [31:0] o;
    k = $urandom_range(0, 26);
    o = $urandom & ((32'd1 << k) - 1);
    if ($urandom_range(0, 1)) o = -o;
    return base + o;
  endfunction

  function automatic logic [31:0] rand_pos();
    return $urandom_range(0, 3) == 0 ? $urandom : jitter(32'h0);
  endfunction

  function automatic logic [15:0] rand_normal();
    return $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic in_t rand_hit();
    in_t it;
    int kind;
    logic [31:0] mx, my, mz;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      if (kind < 20) begin
        mx = (light_x + eye_x) >> 1;
        my = (light_y + eye_y) >> 1;
        mz = (light_z + eye_z) >> 1;
      end else begin
        mx = light_x;
        my = light_y;
        mz = light_z;
      end
      it.point_x = jitter(mx);
      it.point_y = jitter(my);
      it.point_z = jitter(mz);
      it.normal_x = rand_normal();
      it.normal_y = rand_normal();
      it.normal_z = rand_normal();
      if ($urandom_range(0, 9) < 7) it.shininess = 16'($urandom_range(0, 16'h2000));
    end
    return it;
  endfunction

  function automatic in_t hit(logic [31:0] px, py, pz, logic [15:0] nx, ny, nz,
                              logic [15:0] sh, logic [47:0] ks, kd);
    in_t it;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    it.normal_x = nx;
    it.normal_y = ny;
    it.normal_z = nz;
    it.shininess = sh;
    it.specular_rgb = ks;
    it.diffuse_rgb = kd;
    return it;
  endfunction

  task automatic push_random(int count);
    repeat (count) hit_q.push_back(rand_hit());
  endtask

  initial begin
    logic [47:0] half;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    snd_idle = 0;
    rcv_idle = 0;
    want_hold = 0;
    scenes = 0;
    light_x = '0; light_y = '0; light_z = '0; light_rgba = '0;
    eye_x = '0; eye_y = '0; eye_z = '0;
    build_tables();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    half = 48'h4000_4000_4000;
    set_scene(ONE, 2 * ONE, 3 * ONE, 64'h7FFF_7FFF_6000_4000, 3 * ONE, 2 * ONE, ONE);
    hit_q.push_back(hit(ONE, 2 * ONE, 2 * ONE, 0, 0, 16384, 16'h0A00, half, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 3 * ONE, 0, 0, 16384, 16'h0A00, half, half));
    hit_q.push_back(hit(2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 16384, 16'h0800, half, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 4 * ONE, 0, 0, 16384, 16'h0800, half, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 2 * ONE, 0, 0, 16'h7FFF, 16'h0800, half, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 4 * ONE, 0, 0, 16'h8000, 16'h0800, half, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 2 * ONE, 16'hC000, 0, 0, 16'h0800, half, half));
    hit_q.push_back(hit(ONE, ONE, 2 * ONE, 11585, 0, 11585, 16'h0000, half, half));
    hit_q.push_back(hit(ONE, ONE, 2 * ONE, 11585, 0, 11585, 16'hFFFF, half, half));
    hit_q.push_back(hit(0, ONE, 2 * ONE, 9459, 9459, 9459, 16'h0100, '1, '1));
    hit_q.push_back(hit(0, ONE, 2 * ONE, 9459, 9459, 9459, 16'h0100, '0, '0));
    hit_q.push_back(hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        16'hC000, 16'hC000, 16'hC000, 16'h0400, '1, '1));
    hit_q.push_back(hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16384, 16384, 16384, 16'h0400, '1, '1));
    hit_q.push_back(hit(ONE, 2 * ONE, 3 * ONE + 1, 0, 0, 16'hC000, 16'h2000, '1, half));
    hit_q.push_back(hit(ONE, 2 * ONE, 3 * ONE - 1, 0, 16384, 0, 16'h2000, '1, half));
    hit_q.push_back(hit(ONE + 32'h4000, 2 * ONE, 2 * ONE, 0, 0, 16384, 16'h1000, '1, '1));
    wait_drained();

    set_scene(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_random(20);
    wait_drained();
    set_scene(0, 0, 0, '0, 0, 0, 0);
    push_random(20);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = ph == 0 ? 6 : ph == 1 ? 49 : 0;
      rcv_idle = ph == 0 ? 49 : ph == 1 ? 6 : 0;
      for (int sc = 0; sc < 2; sc++) begin
        set_scene(rand_pos(), rand_pos(), rand_pos(), {$urandom, $urandom},
                  rand_pos(), rand_pos(), rand_pos());
        push_random(195);
        if (ph == 0 && sc == 0) want_hold = 1;
        wait_drained();
      end
    end

    wait_drained();
    $display("shaded %0d hit points over %0d light/eye scenes, %0d results checked",
             shaded, scenes, checked);
    $display("covered facing-away, point-at-light, zero half vector, extreme coords and stalls");
    if (mismatches == 0 && shade_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
